>>> hw/rtl/cpr_pkg.sv
package cpr_pkg;

  // value width of the design and the width the drive value saturates to
  localparam int VALUE_WIDTH = 32;
  localparam int DRIVE_W     = (VALUE_WIDTH < 16) ? 16 : ((VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH);

  // datapath widths
  localparam int ACC_W  = 48;  // Q16.32 target and integrators
  localparam int WIDE_W = 50;  // integrator plus increment before clipping
  localparam int ERR_W  = 33;  // exact difference of two Q16.16 values
  localparam int MA_W   = 34;  // multiplier operand a, signed
  localparam int MB_W   = 25;  // multiplier operand b, signed
  localparam int PROD_W = MA_W + MB_W;
  localparam int SUM_W  = PROD_W - 12;  // gain terms after the Q12.12 shift

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_EN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POS_EN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PKP     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PKI     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SKP     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SKI     = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_FB      = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_START   = CFG_IDX_W'(7);

  // register reset values
  localparam logic [23:0] PKP_RST = 24'd196608;
  localparam logic [23:0] PKI_RST = 24'd0;
  localparam logic [23:0] SKP_RST = 24'd131072;
  localparam logic [23:0] SKI_RST = 24'd81920;
  localparam logic [15:0] FB_RST  = 16'd66;

  // multiplier operand a selects
  localparam logic [2:0] A_CMD   = 3'd0;
  localparam logic [2:0] A_ERR   = 3'd1;
  localparam logic [2:0] A_PACC  = 3'd2;
  localparam logic [2:0] A_DRIVE = 3'd3;
  localparam logic [2:0] A_SACC  = 3'd4;

  // multiplier operand b selects
  localparam logic [2:0] B_DT  = 3'd0;
  localparam logic [2:0] B_PKP = 3'd1;
  localparam logic [2:0] B_PKI = 3'd2;
  localparam logic [2:0] B_SKP = 3'd3;
  localparam logic [2:0] B_SKI = 3'd4;
  localparam logic [2:0] B_FB  = 3'd5;

  // datapath operations
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_RAMP  = 4'd1;
  localparam logic [3:0] OP_PERR  = 4'd2;
  localparam logic [3:0] OP_PACC  = 4'd3;
  localparam logic [3:0] OP_LOAD  = 4'd4;
  localparam logic [3:0] OP_ADD   = 4'd5;
  localparam logic [3:0] OP_SETPT = 4'd6;
  localparam logic [3:0] OP_SERR  = 4'd7;
  localparam logic [3:0] OP_SACC  = 4'd8;
  localparam logic [3:0] OP_DRIVE = 4'd9;

  // saturation limits
  localparam logic signed [WIDE_W-1:0] ACC_MAX = WIDE_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
  localparam logic signed [WIDE_W-1:0] ACC_MIN = WIDE_W'(-(64'sd1 <<< (ACC_W - 1)));
  localparam logic signed [SUM_W-1:0]  SP_MAX  = SUM_W'((64'sd1 <<< 31) - 64'sd1);
  localparam logic signed [SUM_W-1:0]  SP_MIN  = SUM_W'(-(64'sd1 <<< 31));
  localparam logic signed [SUM_W-1:0]  DRV_MAX = SUM_W'((64'sd1 <<< (DRIVE_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0]  DRV_MIN = SUM_W'(-(64'sd1 <<< (DRIVE_W - 1)));

  typedef struct packed {
    logic signed [31:0] measured_position;
    logic signed [31:0] measured_speed;
    logic signed [31:0] speed_command;
    logic        [15:0] time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] drive_force;
    logic               saturated;
  } out_word_t;

  typedef struct packed {
    logic        ramp_en;
    logic        pos_en;
    logic [23:0] pkp;
    logic [23:0] pki;
    logic [23:0] skp;
    logic [23:0] ski;
    logic [15:0] fb;
  } cfg_t;

  // target load on a start_target write
  typedef struct packed {
    logic               load;
    logic signed [31:0] value;
  } tload_t;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic [3:0] op;
  } cmd_t;

endpackage

>>> hw/rtl/cpr_cfg.sv
module cpr_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cpr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cpr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output cpr_pkg::cfg_t                   cfg_o,
  output cpr_pkg::tload_t                 tload_o
);

  cpr_pkg::cfg_t cfg_q, cfg_d;
  logic          wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    tload_o.load  = 1'b0;
    tload_o.value = $signed(cfg_data_i[31:0]);
    if (wr) begin
      case (cfg_index_i)
        cpr_pkg::REG_RAMP_EN: cfg_d.ramp_en = cfg_data_i[0];
        cpr_pkg::REG_POS_EN:  cfg_d.pos_en  = cfg_data_i[0];
        cpr_pkg::REG_PKP:     cfg_d.pkp     = cfg_data_i[23:0];
        cpr_pkg::REG_PKI:     cfg_d.pki     = cfg_data_i[23:0];
        cpr_pkg::REG_SKP:     cfg_d.skp     = cfg_data_i[23:0];
        cpr_pkg::REG_SKI:     cfg_d.ski     = cfg_data_i[23:0];
        cpr_pkg::REG_FB:      cfg_d.fb      = cfg_data_i[15:0];
        cpr_pkg::REG_START:   tload_o.load  = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ramp_en <= 1'b1;
      cfg_q.pos_en  <= 1'b1;
      cfg_q.pkp     <= cpr_pkg::PKP_RST;
      cfg_q.pki     <= cpr_pkg::PKI_RST;
      cfg_q.skp     <= cpr_pkg::SKP_RST;
      cfg_q.ski     <= cpr_pkg::SKI_RST;
      cfg_q.fb      <= cpr_pkg::FB_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/cpr_ctrl.sv
module cpr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  logic           ramp_en_i,
  input  logic           pos_en_i,
  output cpr_pkg::cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_RAMP_MUL = 5'd1;
  localparam logic [4:0] S_RAMP_ACC = 5'd2;
  localparam logic [4:0] S_PERR     = 5'd3;
  localparam logic [4:0] S_PACC_MUL = 5'd4;
  localparam logic [4:0] S_PACC_ACC = 5'd5;
  localparam logic [4:0] S_PKP_MUL  = 5'd6;
  localparam logic [4:0] S_PKP_ACC  = 5'd7;
  localparam logic [4:0] S_PKI_MUL  = 5'd8;
  localparam logic [4:0] S_PKI_ACC  = 5'd9;
  localparam logic [4:0] S_FB_MUL   = 5'd10;
  localparam logic [4:0] S_FB_ACC   = 5'd11;
  localparam logic [4:0] S_SERR     = 5'd12;
  localparam logic [4:0] S_SACC_MUL = 5'd13;
  localparam logic [4:0] S_SACC_ACC = 5'd14;
  localparam logic [4:0] S_SKP_MUL  = 5'd15;
  localparam logic [4:0] S_SKP_ACC  = 5'd16;
  localparam logic [4:0] S_SKI_MUL  = 5'd17;
  localparam logic [4:0] S_SKI_ACC  = 5'd18;
  localparam logic [4:0] S_DRV      = 5'd19;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // sequencer
  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q & out_stall_i;
    cmd_o.load_in = 1'b0;
    cmd_o.mul_en  = 1'b0;
    cmd_o.a_sel   = cpr_pkg::A_ERR;
    cmd_o.b_sel   = cpr_pkg::B_DT;
    cmd_o.op      = cpr_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_RAMP_MUL;
        end
      end
      S_RAMP_MUL: begin
        cmd_o.mul_en = ramp_en_i;
        cmd_o.a_sel  = cpr_pkg::A_CMD;
        state_d      = ramp_en_i ? S_RAMP_ACC : S_PERR;
      end
      S_RAMP_ACC: begin
        cmd_o.op = cpr_pkg::OP_RAMP;
        state_d  = S_PERR;
      end
      S_PERR: begin
        cmd_o.op = cpr_pkg::OP_PERR;
        state_d  = pos_en_i ? S_PACC_MUL : S_SERR;
      end
      S_PACC_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_PACC_ACC;
      end
      S_PACC_ACC: begin
        cmd_o.op = cpr_pkg::OP_PACC;
        state_d  = S_PKP_MUL;
      end
      S_PKP_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.b_sel  = cpr_pkg::B_PKP;
        state_d      = S_PKP_ACC;
      end
      S_PKP_ACC: begin
        cmd_o.op = cpr_pkg::OP_LOAD;
        state_d  = S_PKI_MUL;
      end
      S_PKI_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = cpr_pkg::A_PACC;
        cmd_o.b_sel  = cpr_pkg::B_PKI;
        state_d      = S_PKI_ACC;
      end
      S_PKI_ACC: begin
        cmd_o.op = cpr_pkg::OP_ADD;
        state_d  = S_FB_MUL;
      end
      S_FB_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = cpr_pkg::A_DRIVE;
        cmd_o.b_sel  = cpr_pkg::B_FB;
        state_d      = S_FB_ACC;
      end
      S_FB_ACC: begin
        cmd_o.op = cpr_pkg::OP_SETPT;
        state_d  = S_SERR;
      end
      S_SERR: begin
        cmd_o.op = cpr_pkg::OP_SERR;
        state_d  = S_SACC_MUL;
      end
      S_SACC_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_SACC_ACC;
      end
      S_SACC_ACC: begin
        cmd_o.op = cpr_pkg::OP_SACC;
        state_d  = S_SKP_MUL;
      end
      S_SKP_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.b_sel  = cpr_pkg::B_SKP;
        state_d      = S_SKP_ACC;
      end
      S_SKP_ACC: begin
        cmd_o.op = cpr_pkg::OP_LOAD;
        state_d  = S_SKI_MUL;
      end
      S_SKI_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = cpr_pkg::A_SACC;
        cmd_o.b_sel  = cpr_pkg::B_SKI;
        state_d      = S_SKI_ACC;
      end
      S_SKI_ACC: begin
        cmd_o.op = cpr_pkg::OP_ADD;
        state_d  = S_DRV;
      end
      S_DRV: begin
        // hold until the output register can take the new word
        if (out_free) begin
          cmd_o.op    = cpr_pkg::OP_DRIVE;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/cpr_dp.sv
module cpr_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpr_pkg::cmd_t       cmd_i,
  input  cpr_pkg::cfg_t       cfg_i,
  input  cpr_pkg::tload_t     tload_i,
  input  cpr_pkg::in_word_t   in_data_i,
  output cpr_pkg::out_word_t  out_data_o
);

  cpr_pkg::in_word_t                       in_q;
  cpr_pkg::out_word_t                      out_q;
  logic signed [cpr_pkg::PROD_W-1:0]       prod_q;
  logic signed [cpr_pkg::ERR_W-1:0]        err_q, err_d;
  logic signed [cpr_pkg::SUM_W-1:0]        sum_q, sum_d;
  logic signed [cpr_pkg::ACC_W-1:0]        target_q, target_d;
  logic signed [cpr_pkg::ACC_W-1:0]        pacc_q, pacc_d;
  logic signed [cpr_pkg::ACC_W-1:0]        sacc_q, sacc_d;
  logic signed [31:0]                      setpt_q, setpt_d;
  logic signed [31:0]                      drive_q, drive_d;
  logic                                    clip_q, clip_d;

  logic signed [cpr_pkg::MA_W-1:0]         a_op;
  logic signed [cpr_pkg::MB_W-1:0]         b_op;
  logic signed [cpr_pkg::WIDE_W-1:0]       acc_sel, acc_sum, acc_sat;
  logic                                    acc_over;
  logic signed [cpr_pkg::SUM_W-1:0]        prod_s12, prod_s16, sp_sum;
  logic signed [cpr_pkg::SUM_W-1:0]        sp_sat, drv_sat;
  logic                                    drv_over;

  // multiplier operand selection
  always_comb begin
    case (cmd_i.a_sel)
      cpr_pkg::A_CMD:   a_op = {{2{in_q.speed_command[31]}}, in_q.speed_command};
      cpr_pkg::A_ERR:   a_op = {err_q[cpr_pkg::ERR_W-1], err_q};
      cpr_pkg::A_PACC:  a_op = {{2{pacc_q[cpr_pkg::ACC_W-1]}}, pacc_q[cpr_pkg::ACC_W-1:16]};
      cpr_pkg::A_DRIVE: a_op = {{2{drive_q[31]}}, drive_q};
      cpr_pkg::A_SACC:  a_op = {{2{sacc_q[cpr_pkg::ACC_W-1]}}, sacc_q[cpr_pkg::ACC_W-1:16]};
      default:          a_op = '0;
    endcase
    case (cmd_i.b_sel)
      cpr_pkg::B_DT:  b_op = $signed({9'd0, in_q.time_step});
      cpr_pkg::B_PKP: b_op = $signed({1'b0, cfg_i.pkp});
      cpr_pkg::B_PKI: b_op = $signed({1'b0, cfg_i.pki});
      cpr_pkg::B_SKP: b_op = $signed({1'b0, cfg_i.skp});
      cpr_pkg::B_SKI: b_op = $signed({1'b0, cfg_i.ski});
      cpr_pkg::B_FB:  b_op = $signed({9'd0, cfg_i.fb});
      default:        b_op = '0;
    endcase
  end

  // integrator add with 48 bit clipping, shared by target and both integrators
  always_comb begin
    case (cmd_i.op)
      cpr_pkg::OP_RAMP: acc_sel = {{2{target_q[cpr_pkg::ACC_W-1]}}, target_q};
      cpr_pkg::OP_PACC: acc_sel = {{2{pacc_q[cpr_pkg::ACC_W-1]}}, pacc_q};
      default:          acc_sel = {{2{sacc_q[cpr_pkg::ACC_W-1]}}, sacc_q};
    endcase
    acc_sum  = acc_sel + prod_q[cpr_pkg::WIDE_W-1:0];
    acc_over = (acc_sum > cpr_pkg::ACC_MAX) || (acc_sum < cpr_pkg::ACC_MIN);
    acc_sat  = acc_sum;
    if (acc_sum > cpr_pkg::ACC_MAX) begin
      acc_sat = cpr_pkg::ACC_MAX;
    end else if (acc_sum < cpr_pkg::ACC_MIN) begin
      acc_sat = cpr_pkg::ACC_MIN;
    end
  end

  // gain terms, floor shifts of the product register
  assign prod_s12 = prod_q[cpr_pkg::PROD_W-1:12];
  assign prod_s16 = {{4{prod_q[cpr_pkg::PROD_W-1]}}, prod_q[cpr_pkg::PROD_W-1:16]};
  assign sp_sum   = sum_q - prod_s16;

  always_comb begin
    sp_sat = sp_sum;
    if (sp_sum > cpr_pkg::SP_MAX) begin
      sp_sat = cpr_pkg::SP_MAX;
    end else if (sp_sum < cpr_pkg::SP_MIN) begin
      sp_sat = cpr_pkg::SP_MIN;
    end
    drv_over = (sum_q > cpr_pkg::DRV_MAX) || (sum_q < cpr_pkg::DRV_MIN);
    drv_sat  = sum_q;
    if (sum_q > cpr_pkg::DRV_MAX) begin
      drv_sat = cpr_pkg::DRV_MAX;
    end else if (sum_q < cpr_pkg::DRV_MIN) begin
      drv_sat = cpr_pkg::DRV_MIN;
    end
  end

  // state update per operation
  always_comb begin
    target_d = target_q;
    pacc_d   = pacc_q;
    sacc_d   = sacc_q;
    setpt_d  = setpt_q;
    drive_d  = drive_q;
    err_d    = err_q;
    sum_d    = sum_q;
    clip_d   = clip_q;
    case (cmd_i.op)
      cpr_pkg::OP_RAMP: begin
        target_d = acc_sat[cpr_pkg::ACC_W-1:0];
        clip_d   = clip_q | acc_over;
      end
      cpr_pkg::OP_PERR: begin
        err_d = {target_q[cpr_pkg::ACC_W-1], target_q[cpr_pkg::ACC_W-1:16]}
              - {in_q.measured_position[31], in_q.measured_position};
      end
      cpr_pkg::OP_PACC: begin
        pacc_d = acc_sat[cpr_pkg::ACC_W-1:0];
        clip_d = clip_q | acc_over;
      end
      cpr_pkg::OP_LOAD:  sum_d = prod_s12;
      cpr_pkg::OP_ADD:   sum_d = sum_q + prod_s12;
      cpr_pkg::OP_SETPT: setpt_d = sp_sat[31:0];
      cpr_pkg::OP_SERR: begin
        err_d = {setpt_q[31], setpt_q}
              - {in_q.measured_speed[31], in_q.measured_speed};
      end
      cpr_pkg::OP_SACC: begin
        sacc_d = acc_sat[cpr_pkg::ACC_W-1:0];
        clip_d = clip_q | acc_over;
      end
      cpr_pkg::OP_DRIVE: begin
        drive_d = drv_sat[31:0];
        clip_d  = clip_q | drv_over;
      end
      default: ;
    endcase
    if (cmd_i.load_in) begin
      clip_d = 1'b0;
    end
    // the user writes start_target only while idle; the block does not enforce it
    if (tload_i.load) begin
      target_d = {tload_i.value, 16'd0};
    end
  end

  // controller state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      pacc_q   <= '0;
      sacc_q   <= '0;
      setpt_q  <= '0;
      drive_q  <= '0;
    end else begin
      target_q <= target_d;
      pacc_q   <= pacc_d;
      sacc_q   <= sacc_d;
      setpt_q  <= setpt_d;
      drive_q  <= drive_d;
    end
  end

  // working registers and output word
  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    sum_q  <= sum_d;
    clip_q <= clip_d;
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= a_op * b_op;
    end
    if (cmd_i.op == cpr_pkg::OP_DRIVE) begin
      out_q.drive_force <= drv_sat[31:0];
      out_q.saturated   <= clip_q | drv_over;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> hw/rtl/cascaded_pi_joint_regulator.sv
// Cascaded position and speed PI regulator for one joint, signed Q16.16 values.
// Each input word is one control tick; it produces exactly one output word.
// A word goes through one shared 34x25 multiplier with a registered product,
// each multiply followed by an accumulate step; the command ramp and the
// position loop can each be switched off to skip their steps. A tick ends
// when its result enters the output register, which it waits for while the
// last result is stalled there. The next word is accepted while a result
// waits there. start_target writes also reload the position target.
// The user writes configuration only while the block is idle; it is not enforced.
module cascaded_pi_joint_regulator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cpr_pkg::in_word_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cpr_pkg::out_word_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cpr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cpr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  cpr_pkg::cfg_t   cfg;
  cpr_pkg::tload_t tload;
  cpr_pkg::cmd_t   cmd;

  // configuration registers
  cpr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .tload_o     (tload)
  );

  // sequencer
  cpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ramp_en_i   (cfg.ramp_en),
    .pos_en_i    (cfg.pos_en),
    .cmd_o       (cmd)
  );

  // arithmetic and loop state
  cpr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .tload_i    (tload),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
